[hdl/drdf_pkg.sv]
// Shared types, constants and register codes of the detection row decode filter.
`default_nettype none

package drdf_pkg;

  // Parameter defaults
  localparam int DEF_MAX_CLASSES   = 16;
  localparam int DEF_NUM_PROPOSALS = 25200;

  // Field widths
  localparam int VALUE_W  = 16;
  localparam int SCALE_W  = 16;
  localparam int CONF_W   = 16;
  localparam int NC_W     = 5;
  localparam int EDGE_W   = 16;
  localparam int EXT_W    = 15;
  localparam int CLASS_W  = 4;
  localparam int INDEX_W  = 15;
  localparam int APB_AW   = 4;
  localparam int APB_DW   = 32;
  localparam int BOX_N    = 4;

  // Objectness threshold cap: 0.5 in Q0.16
  localparam logic [CONF_W-1:0] HALF_Q16 = 16'h8000;

  // Register reset values
  localparam logic [CONF_W-1:0]  RST_CONFIDENCE  = 16'd26214;
  localparam logic [SCALE_W-1:0] RST_X_SCALE     = 16'd256;
  localparam logic [SCALE_W-1:0] RST_Y_SCALE     = 16'd256;
  localparam logic [NC_W-1:0]    RST_CLASS_COUNT = 5'd1;

  // Box field slots in row order
  localparam int BOX_CX = 0;
  localparam int BOX_CY = 1;
  localparam int BOX_W  = 2;
  localparam int BOX_H  = 3;

  // Register word index (byte address / 4)
  typedef enum logic [1:0] {
    REG_CONFIDENCE  = 2'd0,
    REG_X_SCALE     = 2'd1,
    REG_Y_SCALE     = 2'd2,
    REG_CLASS_COUNT = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [CONF_W-1:0]  confidence;
    logic [SCALE_W-1:0] x_scale;
    logic [SCALE_W-1:0] y_scale;
    logic [NC_W-1:0]    class_count;
  } cfg_t;

  // Row end report from the tracker
  typedef struct packed {
    logic                          row_end;
    logic                          pass;
    logic [BOX_N-1:0][VALUE_W-1:0] box;
    logic [CLASS_W-1:0]            class_id;
    logic [VALUE_W-1:0]            score;
    logic [INDEX_W-1:0]            index;
  } row_info_t;

  typedef struct packed {
    logic signed [EDGE_W-1:0] left;
    logic signed [EDGE_W-1:0] top;
    logic [EXT_W-1:0]         box_width;
    logic [EXT_W-1:0]         box_height;
  } box_px_t;

endpackage

`default_nettype wire

[hdl/detection_row_decode_filter.sv]
// Top level of the detection row decode filter: input stage, row logic, result register.
//
//  channel   | handshake                       | payload
//  ----------+---------------------------------+---------------------------------------
//  input     | value_valid / value_stall       | value
//  result    | result_valid / result_stall     | left top box_width box_height class_id
//            |                                 | score proposal_index
//  config    | psel penable pwrite pready      | paddr pwdata prdata
//
// One value is taken per cycle while value_stall is low.
// The input register feeds the row logic and box scaler, whose result lands in the
// output register; the scaler's 17x16 multiply sets the critical path.
// Synchronous reset empties the pipeline, clears the row state and loads the register reset values.
// A stalled result holds its register; the input stalls only when a passing row end
// waits behind it, other values keep flowing.
`default_nettype none

module detection_row_decode_filter #(
  parameter int MAX_CLASSES   = drdf_pkg::DEF_MAX_CLASSES,
  parameter int NUM_PROPOSALS = drdf_pkg::DEF_NUM_PROPOSALS
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // input stream
  input  wire logic                                value_valid,
  output logic                                     value_stall,
  input  wire logic        [drdf_pkg::VALUE_W-1:0] value,
  // result stream
  output logic                                     result_valid,
  input  wire logic                                result_stall,
  output logic signed      [drdf_pkg::EDGE_W-1:0]  left,
  output logic signed      [drdf_pkg::EDGE_W-1:0]  top,
  output logic             [drdf_pkg::EXT_W-1:0]   box_width,
  output logic             [drdf_pkg::EXT_W-1:0]   box_height,
  output logic             [drdf_pkg::CLASS_W-1:0] class_id,
  output logic             [drdf_pkg::VALUE_W-1:0] score,
  output logic             [drdf_pkg::INDEX_W-1:0] proposal_index,
  // configuration
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic        [drdf_pkg::APB_AW-1:0]  paddr,
  input  wire logic        [drdf_pkg::APB_DW-1:0]  pwdata,
  output logic             [drdf_pkg::APB_DW-1:0]  prdata,
  output logic                                     pready
);
  import drdf_pkg::*;

  cfg_t               cfg;
  row_info_t          info;
  box_px_t            px;
  logic               in_valid;
  logic [VALUE_W-1:0] in_value;
  logic               out_free;
  logic               consume;

  drdf_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  drdf_row_tracker #(
    .MAX_CLASSES   (MAX_CLASSES),
    .NUM_PROPOSALS (NUM_PROPOSALS)
  ) u_row (
    .clk   (clk),
    .rst   (rst),
    .step  (consume),
    .value (in_value),
    .cfg   (cfg),
    .info  (info)
  );

  drdf_box_scale u_scale (
    .box (info.box),
    .cfg (cfg),
    .px  (px)
  );

  // Hold the input stage only when a detection cannot enter the result register
  assign out_free    = !result_valid || !result_stall;
  assign consume     = in_valid && (!info.pass || out_free);
  assign value_stall = in_valid && !consume;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (value_valid && !value_stall) begin
      in_valid <= 1'b1;
    end else if (consume) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (value_valid && !value_stall) begin
      in_value <= value;
    end
  end

  // Result register: load a passing row, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (consume && info.pass) begin
      result_valid <= 1'b1;
    end else if (out_free) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && info.pass) begin
      left           <= px.left;
      top            <= px.top;
      box_width      <= px.box_width;
      box_height     <= px.box_height;
      class_id       <= info.class_id;
      score          <= info.score;
      proposal_index <= info.index;
    end
  end

endmodule

`default_nettype wire

[hdl/drdf_cfg_regs.sv]
// APB-style configuration registers of the detection row decode filter.
`default_nettype none

module drdf_cfg_regs (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [drdf_pkg::APB_AW-1:0] paddr,
  input  wire logic [drdf_pkg::APB_DW-1:0] pwdata,
  output logic      [drdf_pkg::APB_DW-1:0] prdata,
  output logic                             pready,
  output drdf_pkg::cfg_t                   cfg
);
  import drdf_pkg::*;

  logic       wr_en;
  reg_index_t reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = reg_index_t'(paddr[3:2]);

  // Write on the access phase of a transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.confidence  <= RST_CONFIDENCE;
      cfg.x_scale     <= RST_X_SCALE;
      cfg.y_scale     <= RST_Y_SCALE;
      cfg.class_count <= RST_CLASS_COUNT;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_CONFIDENCE:  cfg.confidence  <= pwdata[CONF_W-1:0];
        REG_X_SCALE:     cfg.x_scale     <= pwdata[SCALE_W-1:0];
        REG_Y_SCALE:     cfg.y_scale     <= pwdata[SCALE_W-1:0];
        REG_CLASS_COUNT: cfg.class_count <= pwdata[NC_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the selected register
  always_comb begin
    unique case (reg_sel)
      REG_CONFIDENCE:  prdata = APB_DW'(cfg.confidence);
      REG_X_SCALE:     prdata = APB_DW'(cfg.x_scale);
      REG_Y_SCALE:     prdata = APB_DW'(cfg.y_scale);
      REG_CLASS_COUNT: prdata = APB_DW'(cfg.class_count);
      default:         prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

[hdl/drdf_row_tracker.sv]
// Row position, box capture, objectness test and running class maximum.
`default_nettype none

module drdf_row_tracker #(
  parameter int MAX_CLASSES   = drdf_pkg::DEF_MAX_CLASSES,
  parameter int NUM_PROPOSALS = drdf_pkg::DEF_NUM_PROPOSALS
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         step,
  input  wire logic [drdf_pkg::VALUE_W-1:0] value,
  input  drdf_pkg::cfg_t                    cfg,
  output drdf_pkg::row_info_t               info
);
  import drdf_pkg::*;

  localparam int POS_W = $clog2(MAX_CLASSES + 5);
  localparam int CMP_W = ((POS_W > NC_W) ? POS_W : NC_W) + 1;
  localparam int CNT_W = (NUM_PROPOSALS > 1) ? $clog2(NUM_PROPOSALS) : 1;

  logic [POS_W-1:0]              position;
  logic [CNT_W-1:0]              proposal_count;
  logic [BOX_N-1:0][VALUE_W-1:0] box_fields;
  logic                          objectness_pass;
  logic [VALUE_W-1:0]            best_score;
  logic [CLASS_W-1:0]            best_class;

  logic                          objectness_pass_next;
  logic [VALUE_W-1:0]            best_score_next;
  logic [CLASS_W-1:0]            best_class_next;
  logic [CNT_W-1:0]              proposal_count_next;

  logic [CMP_W-1:0]   nc_ext;
  logic [CMP_W-1:0]   eff_classes;
  logic [CMP_W-1:0]   last_pos;
  logic [POS_W-1:0]   cls;
  logic [CONF_W-1:0]  obj_th;
  logic [CNT_W:0]     count_inc;
  logic               row_end;

  // Effective class count: zero acts as one, clamp at the maximum
  always_comb begin
    nc_ext = CMP_W'(cfg.class_count);
    if (cfg.class_count == '0) begin
      eff_classes = CMP_W'(1);
    end else if (nc_ext > CMP_W'(MAX_CLASSES)) begin
      eff_classes = CMP_W'(MAX_CLASSES);
    end else begin
      eff_classes = nc_ext;
    end
    last_pos = eff_classes + CMP_W'(4);
    row_end  = CMP_W'(position) >= last_pos;
  end

  // Objectness and running-max updates for the current element
  always_comb begin
    obj_th               = (cfg.confidence < HALF_Q16) ? cfg.confidence : HALF_Q16;
    cls                  = position - POS_W'(5);
    objectness_pass_next = objectness_pass;
    best_score_next      = best_score;
    best_class_next      = best_class;
    if (position == POS_W'(4)) begin
      objectness_pass_next = value >= obj_th;
    end else if (position > POS_W'(4)) begin
      if (position == POS_W'(5) || value > best_score) begin
        best_score_next = value;
        best_class_next = CLASS_W'(cls);
      end
    end
  end

  // Row counter wraps at the frame size
  always_comb begin
    count_inc = {1'b0, proposal_count} + (CNT_W+1)'(1);
    if (count_inc >= (CNT_W+1)'(NUM_PROPOSALS)) begin
      proposal_count_next = '0;
    end else begin
      proposal_count_next = count_inc[CNT_W-1:0];
    end
  end

  // Advance state on each consumed element
  always_ff @(posedge clk) begin
    if (rst) begin
      position        <= '0;
      proposal_count  <= '0;
      box_fields      <= '0;
      objectness_pass <= 1'b0;
      best_score      <= '0;
      best_class      <= '0;
    end else if (step) begin
      if (position < POS_W'(4)) begin
        box_fields[position[1:0]] <= value;
      end
      if (row_end) begin
        position        <= '0;
        objectness_pass <= 1'b0;
        best_score      <= '0;
        best_class      <= '0;
        proposal_count  <= proposal_count_next;
      end else begin
        position        <= position + POS_W'(1);
        objectness_pass <= objectness_pass_next;
        best_score      <= best_score_next;
        best_class      <= best_class_next;
      end
    end
  end

  // Report the row outcome for the current element
  always_comb begin
    info.row_end  = row_end;
    info.pass     = row_end && objectness_pass_next && (best_score_next >= cfg.confidence);
    info.box      = box_fields;
    info.class_id = best_class_next;
    info.score    = best_score_next;
    info.index    = INDEX_W'(32'(proposal_count));
  end

endmodule

`default_nettype wire

[hdl/drdf_box_scale.sv]
// Scales the captured box to image pixels with truncation and saturation.
`default_nettype none

module drdf_box_scale (
  input  wire logic [drdf_pkg::BOX_N-1:0][drdf_pkg::VALUE_W-1:0] box,
  input  drdf_pkg::cfg_t                                         cfg,
  output drdf_pkg::box_px_t                                      px
);
  import drdf_pkg::*;

  // Edge: (2*center - size) * scale / 2^14, truncated toward zero
  function automatic logic [EDGE_W-1:0] edge_px(input logic [VALUE_W-1:0] center,
                                                input logic [VALUE_W-1:0] size,
                                                input logic [SCALE_W-1:0] scale);
    logic signed [VALUE_W+1:0] diff;
    logic                      neg;
    logic [VALUE_W:0]          mag;
    logic [32:0]               prod;
    logic [18:0]               q;
    logic [EDGE_W-1:0]         res;
    diff = $signed({1'b0, center, 1'b0}) - $signed({2'b00, size});
    neg  = diff[VALUE_W+1];
    mag  = neg ? (VALUE_W+1)'(-diff) : diff[VALUE_W:0];
    prod = 33'(mag) * 33'(scale);
    q    = prod[32:14];
    if (neg) begin
      res = (q > 19'd32768) ? 16'h8000 : (~q[15:0] + 16'd1);
    end else begin
      res = (q > 19'd32767) ? 16'h7FFF : q[15:0];
    end
    return res;
  endfunction

  // Extent: size * scale / 2^13, saturated to 15 bits
  function automatic logic [EXT_W-1:0] extent_px(input logic [VALUE_W-1:0] size,
                                                 input logic [SCALE_W-1:0] scale);
    logic [31:0] prod;
    logic [18:0] p;
    prod = 32'(size) * 32'(scale);
    p    = prod[31:13];
    return (p > 19'd32767) ? 15'h7FFF : p[14:0];
  endfunction

  always_comb begin
    px.left       = edge_px(box[BOX_CX], box[BOX_W], cfg.x_scale);
    px.top        = edge_px(box[BOX_CY], box[BOX_H], cfg.y_scale);
    px.box_width  = extent_px(box[BOX_W], cfg.x_scale);
    px.box_height = extent_px(box[BOX_H], cfg.y_scale);
  end

endmodule

`default_nettype wire

[hdl/drdf_checker.sv]
// Port-level checks of the detection row decode filter, bound to the top level.
`default_nettype none

module drdf_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        value_valid,
  input wire logic        value_stall,
  input wire logic        result_valid,
  input wire logic        result_stall,
  input wire logic [15:0] left,
  input wire logic [15:0] top,
  input wire logic [14:0] box_width,
  input wire logic [14:0] box_height,
  input wire logic [3:0]  class_id,
  input wire logic [15:0] score,
  input wire logic [14:0] proposal_index
);

  // Stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(left) && $stable(top)
      && $stable(box_width) && $stable(box_height) && $stable(class_id)
      && $stable(score) && $stable(proposal_index))
    else $error("stalled result changed");

  // Input stalls only behind a blocked result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    value_stall |-> result_valid && result_stall)
    else $error("input stalled with result side free");

  // A fresh result follows a value accepted into the input register
  a_result_lag: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(value_valid && !value_stall, 2))
    else $error("result without an accepted value");

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

bind detection_row_decode_filter drdf_checker u_drdf_checker (.*);

`default_nettype wire

[test/testbench.sv]
// Self-checking testbench for the detection row decode filter: stimulus, scoreboard, checks.
`timescale 1ns / 1ps

module testbench;
  import drdf_pkg::*;

  // One detection as it leaves the block
  typedef struct {
    logic signed [EDGE_W-1:0] left;
    logic signed [EDGE_W-1:0] top;
    logic [EXT_W-1:0]         box_width;
    logic [EXT_W-1:0]         box_height;
    logic [CLASS_W-1:0]       class_id;
    logic [VALUE_W-1:0]       score;
    logic [INDEX_W-1:0]       proposal_index;
  } detection_t;

  // Tracks rows as they stream in and holds the detections still owed by the block
  class detection_scoreboard;
    logic [CONF_W-1:0]  confidence;
    logic [SCALE_W-1:0] x_scale;
    logic [SCALE_W-1:0] y_scale;
    logic [NC_W-1:0]    class_count;
    int                 position;
    int                 proposal_count;
    logic [VALUE_W-1:0] box [BOX_N];
    bit                 object_ok;
    logic [VALUE_W-1:0] best_score;
    int                 best_class;
    detection_t         owed_q [$];
    int                 failures;

    function new();
      confidence     = RST_CONFIDENCE;
      x_scale        = RST_X_SCALE;
      y_scale        = RST_Y_SCALE;
      class_count    = RST_CLASS_COUNT;
      position       = 0;
      proposal_count = 0;
      foreach (box[i]) box[i] = '0;
      object_ok      = 1'b0;
      best_score     = '0;
      best_class     = 0;
      failures       = 0;
    endfunction

    function void write_register(reg_index_t idx, logic [APB_DW-1:0] data);
      case (idx)
        REG_CONFIDENCE:  confidence  = data[CONF_W-1:0];
        REG_X_SCALE:     x_scale     = data[SCALE_W-1:0];
        REG_Y_SCALE:     y_scale     = data[SCALE_W-1:0];
        REG_CLASS_COUNT: class_count = data[NC_W-1:0];
        default: ;
      endcase
    endfunction

    // Box edge: (2*center - size) in 2^-6 px times Q8.8 scale, truncated toward zero
    function logic [EDGE_W-1:0] scaled_edge(logic [15:0] center, logic [15:0] size,
                                            logic [15:0] scale);
      longint diff;
      longint mag;
      longint q;
      diff = 2 * longint'(center) - longint'(size);
      mag  = (diff < 0) ? -diff : diff;
      q    = (mag * longint'(scale)) / 16384;
      if (diff < 0) q = -q;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return q[EDGE_W-1:0];
    endfunction

    // Box extent: Q11.5 size times Q8.8 scale, saturated to 15 bits
    function logic [EXT_W-1:0] scaled_extent(logic [15:0] size, logic [15:0] scale);
      longint p;
      p = (longint'(size) * longint'(scale)) >>> 13;
      if (p > 32767) p = 32767;
      return p[EXT_W-1:0];
    endfunction

    // Advance the row state by one accepted value; queue a detection on a passing row end
    function void note_value(logic [VALUE_W-1:0] v);
      int                 row_last;
      logic [CONF_W-1:0]  th;
      detection_t         d;
      if (class_count == 0) row_last = 5;
      else if (class_count > DEF_MAX_CLASSES) row_last = 4 + DEF_MAX_CLASSES;
      else row_last = 4 + class_count;

      if (position < 4) begin
        box[position] = v;
      end else if (position == 4) begin
        th = (confidence < HALF_Q16) ? confidence : HALF_Q16;
        object_ok = (v >= th);
      end else if (position == 5 || v > best_score) begin
        best_score = v;
        best_class = position - 5;
      end

      if (position >= row_last) begin
        if (object_ok && best_score >= confidence) begin
          d.left           = scaled_edge(box[BOX_CX], box[BOX_W], x_scale);
          d.top            = scaled_edge(box[BOX_CY], box[BOX_H], y_scale);
          d.box_width      = scaled_extent(box[BOX_W], x_scale);
          d.box_height     = scaled_extent(box[BOX_H], y_scale);
          d.class_id       = CLASS_W'(best_class);
          d.score          = best_score;
          d.proposal_index = INDEX_W'(proposal_count);
          owed_q = {owed_q, d};
        end
        position   = 0;
        object_ok  = 1'b0;
        best_score = '0;
        best_class = 0;
        proposal_count++;
        if (proposal_count >= DEF_NUM_PROPOSALS) proposal_count = 0;
      end else begin
        position++;
      end
    endfunction

    function void compare_field(string name, logic signed [16:0] want,
                                logic signed [16:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        failures++;
      end
    endfunction

    // Match one accepted detection against the oldest one owed
    function void check_detection(detection_t got);
      detection_t want;
      if (owed_q.size() == 0) begin
        $error("detection with no row waiting for it (proposal_index %0d)",
               got.proposal_index);
        failures++;
        return;
      end
      want = owed_q.pop_front();
      compare_field("left", want.left, got.left);
      compare_field("top", want.top, got.top);
      compare_field("box_width", want.box_width, got.box_width);
      compare_field("box_height", want.box_height, got.box_height);
      compare_field("class_id", want.class_id, got.class_id);
      compare_field("score", want.score, got.score);
      compare_field("proposal_index", want.proposal_index, got.proposal_index);
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    function void drop_pending();
      failures += owed_q.size();
      owed_q.delete();
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   value_valid = 1'b0;
  logic                   value_stall;
  logic [VALUE_W-1:0]     value = '0;
  logic                   result_valid;
  logic                   result_stall = 1'b0;
  logic signed [EDGE_W-1:0] left;
  logic signed [EDGE_W-1:0] top;
  logic [EXT_W-1:0]       box_width;
  logic [EXT_W-1:0]       box_height;
  logic [CLASS_W-1:0]     class_id;
  logic [VALUE_W-1:0]     score;
  logic [INDEX_W-1:0]     proposal_index;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [APB_AW-1:0]      paddr = '0;
  logic [APB_DW-1:0]      pwdata = '0;
  logic [APB_DW-1:0]      prdata;
  logic                   pready;

  detection_scoreboard    sb;
  int                     gap_max = 0;
  int                     stall_max = 0;
  int                     stall_left = 0;

  always #2 clk = ~clk;

  detection_row_decode_filter u_top (
    .clk            (clk),
    .rst            (rst),
    .value_valid    (value_valid),
    .value_stall    (value_stall),
    .value          (value),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .left           (left),
    .top            (top),
    .box_width      (box_width),
    .box_height     (box_height),
    .class_id       (class_id),
    .score          (score),
    .proposal_index (proposal_index),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // Check each accepted detection, then hold stall for a drawn number of offered cycles
  always @(posedge clk) begin : result_side
    detection_t seen;
    int         hold;
    if (!rst && result_valid === 1'b1 && !result_stall) begin
      seen.left           = left;
      seen.top            = top;
      seen.box_width      = box_width;
      seen.box_height     = box_height;
      seen.class_id       = class_id;
      seen.score          = score;
      seen.proposal_index = proposal_index;
      sb.check_detection(seen);
      hold = $urandom_range(0, stall_max);
      result_stall <= (hold != 0);
      stall_left   <= hold;
    end else if (!rst && result_valid === 1'b1) begin
      if (stall_left <= 1) result_stall <= 1'b0;
      stall_left <= stall_left - 1;
    end
  end

  // Offer one value after a drawn gap and hold it until the block takes it
  task automatic send_value(input logic [VALUE_W-1:0] v);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      value_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    value_valid <= 1'b1;
    value       <= v;
    @(posedge clk);
    while (value_stall) @(posedge clk);
    sb.note_value(v);
  endtask

  // Box and objectness of one row; class scores follow separately
  task automatic send_row(input logic [15:0] cx, input logic [15:0] cy,
                          input logic [15:0] w, input logic [15:0] h,
                          input logic [15:0] obj);
    send_value(cx);
    send_value(cy);
    send_value(w);
    send_value(h);
    send_value(obj);
  endtask

  // Draw the next element according to where the row stands
  function automatic logic [VALUE_W-1:0] pick_element(int pos, bit noisy,
                                                      logic [15:0] tie_score);
    logic [CONF_W-1:0] th;
    th = (sb.confidence < HALF_Q16) ? sb.confidence : HALF_Q16;
    if (noisy) return 16'($urandom);
    if (pos < 4) begin
      case ($urandom_range(0, 5)) inside
        0:       return 16'h0000;
        1:       return 16'hFFFF;
        [2:3]:   return 16'($urandom_range(0, 16'h3FFF));
        default: return 16'($urandom);
      endcase
    end
    if (pos == 4) begin
      case ($urandom_range(0, 7))
        0:       return th;
        1:       return th - 16'd1;
        2:       return 16'($urandom);
        default: return 16'($urandom_range(th, 16'hFFFF));
      endcase
    end
    case ($urandom_range(0, 7)) inside
      [0:1]:   return tie_score;
      2:       return sb.confidence;
      3:       return sb.confidence - 16'd1;
      4:       return 16'hFFFF;
      5:       return 16'($urandom);
      default: return 16'($urandom_range(sb.confidence, 16'hFFFF));
    endcase
  endfunction

  // Stream well-formed rows with random content, an occasional noise row among them
  task automatic send_items(input int n);
    bit          noisy;
    logic [15:0] tie_score;
    noisy     = 1'b0;
    tie_score = 16'($urandom_range(sb.confidence, 16'hFFFF));
    repeat (n) begin
      if (sb.position == 0) begin
        noisy     = ($urandom_range(0, 7) == 0);
        tie_score = 16'($urandom_range(sb.confidence, 16'hFFFF));
      end
      send_value(pick_element(sb.position, noisy, tie_score));
    end
  endtask

  // Drop valid, wait for every owed detection, then let the pipeline empty
  task automatic settle();
    int waited;
    waited = 0;
    value_valid <= 1'b0;
    while (sb.pending() != 0 && waited < 1000) begin
      @(posedge clk);
      waited++;
    end
    if (sb.pending() != 0) begin
      $error("%0d expected detections never arrived", sb.pending());
      sb.drop_pending();
    end
    repeat (8) @(posedge clk);
  endtask

  // Configuration write: setup cycle, then access cycle until pready
  task automatic write_reg(input reg_index_t idx, input logic [APB_DW-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.write_register(idx, data);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin : stimulus
    int          phase;
    logic [15:0] conf;
    logic [15:0] xs;
    logic [15:0] ys;
    logic [4:0]  nc;
    sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed rows at reset settings: field extremes, exact thresholds, a rejected row
    send_row(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF);
    send_value(16'hFFFF);
    send_row(16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, RST_CONFIDENCE);
    send_value(RST_CONFIDENCE);
    send_row(16'h1234, 16'h5678, 16'h0400, 16'h0800, RST_CONFIDENCE - 16'd1);
    send_value(16'hFFFF);
    settle();

    // Tied class scores on the first two classes; the higher third score wins
    write_reg(REG_CLASS_COUNT, 32'd3);
    send_row(16'h2000, 16'h1000, 16'h0200, 16'h0300, 16'hC000);
    send_value(16'h9000);
    send_value(16'h9000);
    send_value(16'hA000);
    settle();

    // Random phases; a phase may end mid-row so settings change inside a row
    for (phase = 0; phase < 14; phase++) begin
      case (phase)
        0: begin conf = 16'h0000;       xs = 16'hFFFF; ys = 16'h0000; nc = 5'd0;  end
        1: begin conf = 16'hFFFF;       xs = 16'h0000; ys = 16'hFFFF; nc = 5'd31; end
        2: begin conf = HALF_Q16;       xs = 16'h0100; ys = 16'h0100; nc = 5'd16; end
        3: begin conf = HALF_Q16 + 1'b1; xs = 16'h0180; ys = 16'h0080; nc = 5'd17; end
        default: begin
          conf = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                             : 16'($urandom_range(0, 16'h9000));
          xs   = ($urandom_range(0, 1) == 0) ? 16'($urandom)
                                             : 16'($urandom_range(16'h0080, 16'h0300));
          ys   = 16'($urandom);
          nc   = ($urandom_range(0, 1) == 0) ? 5'($urandom_range(0, 4))
                                             : 5'($urandom_range(0, 31));
        end
      endcase
      write_reg(REG_CONFIDENCE, {16'h0, conf});
      write_reg(REG_X_SCALE, {16'h0, xs});
      write_reg(REG_Y_SCALE, {16'h0, ys});
      write_reg(REG_CLASS_COUNT, {27'h0, nc});
      gap_max   = (phase % 3 == 1) ? 0 : 3;
      stall_max = (phase % 4 == 2) ? 0 : 3;
      send_items($urandom_range(40, 70));
      settle();
    end

    if (sb.failures == 0) begin
      $display("** detection_row_decode_filter: PASSED **");
    end else begin
      $display("** detection_row_decode_filter: FAILED **");
    end
    $finish;
  end

  // Give up if the run hangs
  initial begin
    #4_000_000;
    $display("** detection_row_decode_filter: FAILED **");
    $finish;
  end

endmodule
